FILE: rtl/rfrag_pkg.sv
// Shared constants, types and helpers of the rail fence read address generator.
`default_nettype none

package rfrag_pkg;

    // Field and register widths fixed by the interface.
    localparam int RAIL_W              = 8;
    localparam int LEN_W               = 24;
    localparam int CFG_INDEX_W         = 1;
    localparam int CFG_DATA_W          = 24;
    localparam int OFFSET_BITS_DEFAULT = 24;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_RAIL_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_LENGTH = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [RAIL_W-1:0] RAIL_COUNT_RESET  = 8'd3;
    localparam logic [LEN_W-1:0]  DATA_LENGTH_RESET = 24'd0;

    // Rail counts below the minimum fall back to the default count.
    localparam logic [RAIL_W-1:0] MIN_RAILS     = 8'd2;
    localparam logic [RAIL_W-1:0] DEFAULT_RAILS = 8'd3;

    // Walk state other than the offset itself.
    typedef struct packed {
        logic              running;
        logic              odd_step;
        logic [RAIL_W-1:0] rail;
    } rfrag_ctl_t;

    // Width of the running offset: it must hold an offset plus the largest step.
    function automatic int next_width(input int offset_bits);
        return (offset_bits > 9) ? offset_bits + 1 : 10;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rfrag_walk.sv
// Next-offset logic: settles the walk state, emits at most one offset and advances the walk.
`default_nettype none

module rfrag_walk #(
    parameter int OFFSET_BITS = rfrag_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire logic                                          restart,
    input  wire logic [rfrag_pkg::RAIL_W-1:0]                  rail_count,
    input  wire logic [rfrag_pkg::next_width(OFFSET_BITS)-1:0] len,
    input  wire rfrag_pkg::rfrag_ctl_t                         ctl_in,
    input  wire logic [rfrag_pkg::next_width(OFFSET_BITS)-1:0] offset_in,
    output logic                                               emit,
    output logic                                               last,
    output logic [OFFSET_BITS-1:0]                             out_offset,
    output logic [rfrag_pkg::RAIL_W-1:0]                       out_rail,
    output rfrag_pkg::rfrag_ctl_t                              ctl_out,
    output logic [rfrag_pkg::next_width(OFFSET_BITS)-1:0]      offset_out
);

    localparam int NEXT_W = rfrag_pkg::next_width(OFFSET_BITS);

    always_comb begin
        logic [rfrag_pkg::RAIL_W-1:0] rails;
        logic [rfrag_pkg::RAIL_W-1:0] rails_m1;
        logic [rfrag_pkg::RAIL_W-1:0] half;
        logic [rfrag_pkg::RAIL_W-1:0] rail_a;
        logic [rfrag_pkg::RAIL_W-1:0] rail_b;
        logic [NEXT_W-1:0]            off_a;
        logic [NEXT_W-1:0]            off_b;
        logic                         run_a;
        logic                         run_b;
        logic                         odd_a;
        logic                         odd_b;

        rails    = (rail_count < rfrag_pkg::MIN_RAILS) ? rfrag_pkg::DEFAULT_RAILS : rail_count;
        rails_m1 = rails - 8'd1;

        // A restart begins at rail zero, offset zero; empty data never starts.
        if (restart) begin
            run_a  = (len != '0);
            rail_a = '0;
            off_a  = '0;
            odd_a  = 1'b0;
        end else begin
            run_a  = ctl_in.running;
            rail_a = ctl_in.rail;
            off_a  = offset_in;
            odd_a  = ctl_in.odd_step;
        end

        // Registers may have changed since the last item, so settle the state first.
        if (run_a) begin
            if (rail_a >= rails) begin
                run_a = 1'b0;
            end else if (off_a >= len) begin
                rail_a = rail_a + 8'd1;
                off_a  = NEXT_W'(rail_a);
                odd_a  = 1'b0;
                if ((rail_a >= rails) || (NEXT_W'(rail_a) >= len)) begin
                    run_a = 1'b0;
                end
            end
        end

        emit       = run_a;
        out_offset = off_a[OFFSET_BITS-1:0];
        out_rail   = rail_a;

        // Steps alternate between 2(R-1-r) and 2r; a zero step becomes 2(R-1).
        half = odd_a ? rail_a : (rails_m1 - rail_a);
        if (half == '0) begin
            half = rails_m1;
        end
        off_b  = off_a + NEXT_W'({half, 1'b0});
        rail_b = rail_a;
        odd_b  = ~odd_a;
        run_b  = 1'b1;
        if (off_b >= len) begin
            rail_b = rail_a + 8'd1;
            off_b  = NEXT_W'(rail_b);
            odd_b  = 1'b0;
            if ((rail_b >= rails) || (NEXT_W'(rail_b) >= len)) begin
                run_b = 1'b0;
            end
        end
        last = ~run_b;

        if (run_a) begin
            ctl_out    = '{running: run_b, odd_step: odd_b, rail: rail_b};
            offset_out = off_b;
        end else begin
            ctl_out    = '{running: run_a, odd_step: odd_a, rail: rail_a};
            offset_out = off_a;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rfrag_out_buf.sv
// Result register with a skid stage that takes one item while the result register is stalled.
`default_nettype none

module rfrag_out_buf #(
    parameter int DATA_W = 33
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] skid_data_reg;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
                out_data_reg  <= in_data;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= in_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while the result register is empty");

endmodule

`default_nettype wire

FILE: rtl/rail_fence_read_address_generator.sv
// Top level of the rail fence read address generator: registers, walk state and result buffer.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_restart
//  m_        out        m_valid / m_ready      m_source_offset, m_rail_index, m_last
//  cfg_      in         cfg_we (no wait)       cfg_index, cfg_wdata
//
// Every accepted item is handled in the cycle it is accepted; its offset, if any,
// goes to the result register for the m_ side. The settle, add and compare path
// runs from the walk state registers to the result register. A stalled result is
// parked in a skid stage; s_ready drops only while that stage is full, so one item
// per cycle is sustained while it is empty. Reset (aresetn low, synchronous)
// clears the walk to idle, rail_count to 3 and data_length to 0.
`default_nettype none

module rail_fence_read_address_generator #(
    parameter int OFFSET_BITS = rfrag_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Request channel.
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_restart,
    // Result channel.
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [OFFSET_BITS-1:0]                    m_source_offset,
    output logic [rfrag_pkg::RAIL_W-1:0]              m_rail_index,
    output logic                                      m_last,
    // Configuration write port.
    input  wire logic                                 cfg_we,
    input  wire logic [rfrag_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rfrag_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int NEXT_W   = rfrag_pkg::next_width(OFFSET_BITS);
    // Only as many length bits as an offset can address take part.
    localparam int LEN_BITS = (OFFSET_BITS < rfrag_pkg::LEN_W) ? OFFSET_BITS : rfrag_pkg::LEN_W;
    localparam int RES_W    = OFFSET_BITS + rfrag_pkg::RAIL_W + 1;

    // Configuration registers.
    logic [rfrag_pkg::RAIL_W-1:0] rail_count_reg;
    logic [rfrag_pkg::LEN_W-1:0]  data_length_reg;

    // Walk state: the offset to emit next, and which rail and step phase it is in.
    rfrag_pkg::rfrag_ctl_t ctl_reg;
    rfrag_pkg::rfrag_ctl_t ctl_next;
    logic [NEXT_W-1:0]     offset_reg;
    logic [NEXT_W-1:0]     offset_next;

    logic                         accept;
    logic [NEXT_W-1:0]            len;
    logic                         emit;
    logic                         last;
    logic [OFFSET_BITS-1:0]       walk_offset;
    logic [rfrag_pkg::RAIL_W-1:0] walk_rail;
    logic [RES_W-1:0]             res_in;
    logic [RES_W-1:0]             res_out;

    assign accept = s_valid & s_ready;
    assign len    = NEXT_W'(data_length_reg[LEN_BITS-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail_count_reg  <= rfrag_pkg::RAIL_COUNT_RESET;
            data_length_reg <= rfrag_pkg::DATA_LENGTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                rfrag_pkg::CFG_RAIL_COUNT:  rail_count_reg  <= cfg_wdata[rfrag_pkg::RAIL_W-1:0];
                rfrag_pkg::CFG_DATA_LENGTH: data_length_reg <= cfg_wdata[rfrag_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // The walk state moves only when an item is accepted; an idle request leaves it alone.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg    <= '0;
            offset_reg <= '0;
        end else if (accept) begin
            ctl_reg    <= ctl_next;
            offset_reg <= offset_next;
        end
    end

    rfrag_walk #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_walk (
        .restart    (s_restart),
        .rail_count (rail_count_reg),
        .len        (len),
        .ctl_in     (ctl_reg),
        .offset_in  (offset_reg),
        .emit       (emit),
        .last       (last),
        .out_offset (walk_offset),
        .out_rail   (walk_rail),
        .ctl_out    (ctl_next),
        .offset_out (offset_next)
    );

    assign res_in = {walk_offset, walk_rail, last};

    // Only requests that yield an offset produce a result item.
    rfrag_out_buf #(
        .DATA_W (RES_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept & emit),
        .in_data   (res_in),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    assign m_source_offset = res_out[RES_W-1 -: OFFSET_BITS];
    assign m_rail_index    = res_out[rfrag_pkg::RAIL_W:1];
    assign m_last          = res_out[0];

    // The last offset of a sequence leaves the walk idle.
    a_last_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit && last) |=> !ctl_reg.running)
        else $error("walk still running after the last offset");

    // Any other offset leaves the walk running.
    a_more_keeps_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit && !last) |=> ctl_reg.running)
        else $error("walk stopped before the last offset");

    // An emitted offset always lies inside the data.
    a_offset_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit) |-> (NEXT_W'(walk_offset) < len))
        else $error("emitted offset at or beyond the data length");

    // A restart on non-empty data starts at rail zero, offset zero.
    a_restart_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_restart && (len != '0)) |-> (emit && (walk_offset == '0) && (walk_rail == '0)))
        else $error("restart did not begin at rail zero, offset zero");

endmodule

`default_nettype wire

FILE: dv/rail_read_checker.sv
// Checker that predicts the rail fence read offsets and compares them with the result channel.
`default_nettype none

module rail_read_checker
    import rfrag_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire logic                   s_restart,
    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire logic [OFFSET_BITS-1:0] m_source_offset,
    input  wire logic [RAIL_W-1:0]      m_rail_index,
    input  wire logic                   m_last,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [RAIL_W-1:0]      rail;
        logic                   last;
    } rail_read_t;

    rail_read_t reads_due[$];

    // Shadow copies of the registers and of the walk.
    logic [RAIL_W-1:0] key_rails;
    logic [LEN_W-1:0]  span;
    int unsigned       walk_offset;
    int unsigned       walk_rail;
    bit                walk_odd;
    bit                walk_on;

    initial fail_count = 0;

    function automatic int unsigned rail_total();
        return (key_rails < MIN_RAILS) ? DEFAULT_RAILS : key_rails;
    endfunction

    // Moves to the next rail when the current one has run past the data, or ends the walk.
    function automatic void settle_walk();
        int unsigned total;
        total = rail_total();
        if (!walk_on)
            return;
        if (walk_rail >= total) begin
            walk_on = 1'b0;
            return;
        end
        if (walk_offset >= span) begin
            walk_rail   = walk_rail + 1;
            walk_offset = walk_rail;
            walk_odd    = 1'b0;
            if (walk_rail >= total || walk_offset >= span)
                walk_on = 1'b0;
        end
    endfunction

    function automatic bit next_read(input logic restart, output rail_read_t rd);
        int unsigned total;
        int unsigned stride;
        total = rail_total();
        rd    = '0;
        if (restart) begin
            walk_on     = (span != 0);
            walk_rail   = 0;
            walk_offset = 0;
            walk_odd    = 1'b0;
        end
        settle_walk();
        if (!walk_on)
            return 1'b0;
        rd.offset = walk_offset[OFFSET_BITS-1:0];
        rd.rail   = walk_rail[RAIL_W-1:0];
        stride    = walk_odd ? 2 * walk_rail : 2 * (total - 1 - walk_rail);
        if (stride == 0)
            stride = 2 * (total - 1);
        walk_offset = walk_offset + stride;
        walk_odd    = !walk_odd;
        settle_walk();
        rd.last = !walk_on;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        rail_read_t got;
        rail_read_t want;
        if (!aresetn) begin
            key_rails   = RAIL_COUNT_RESET;
            span        = DATA_LENGTH_RESET;
            walk_offset = 0;
            walk_rail   = 0;
            walk_odd    = 1'b0;
            walk_on     = 1'b0;
            reads_due.delete();
        end else begin
            // A result never leaves in the cycle its item is taken, so compare first.
            if (m_valid && m_ready) begin
                got = '{m_source_offset, m_rail_index, m_last};
                if (reads_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected offset %0d rail %0d last %0b",
                                              got.offset, got.rail, got.last));
                end else begin
                    want = reads_due.pop_front();
                    if (got.offset !== want.offset)
                        report_mismatch($sformatf("source_offset %0d, expected %0d",
                                                  got.offset, want.offset));
                    if (got.rail !== want.rail)
                        report_mismatch($sformatf("rail_index %0d, expected %0d",
                                                  got.rail, want.rail));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  got.last, want.last));
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_RAIL_COUNT)
                    key_rails = cfg_wdata[RAIL_W-1:0];
                else if (cfg_index == CFG_DATA_LENGTH)
                    span = cfg_wdata[LEN_W-1:0];
            end
            if (s_valid && s_ready) begin
                if (next_read(s_restart, want))
                    reads_due.push_back(want);
            end
        end
        pending = reads_due.size();
    end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench top: clock, reset, request and register stimulus, result-side stalls and the verdict.
`default_nettype none

module tb;
    import rfrag_pkg::*;

    localparam int OFFSET_W = OFFSET_BITS_DEFAULT;

    // The two request kinds carried by s_restart.
    localparam logic WALK_ADVANCE = 1'b0;
    localparam logic WALK_RESTART = 1'b1;

    // Number of requests in the random part that are expected to yield an offset.
    localparam int ITEMS_TARGET = 450;
    // The last stretch of the run is driven without any idling.
    localparam int CALM_FROM    = 380;
    // Longest sequence walked in one go; long lengths are cut short.
    localparam int SEQ_CAP      = 60;
    // Receiver hold-off long enough to fill the skid stage and stall requests.
    localparam int HOLD_CYCLES  = 80;
    // Extra cycles let pass after the last predicted offset before the block counts as idle.
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 300000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_restart;
    logic                   m_valid;
    logic                   m_ready;
    logic [OFFSET_W-1:0]    m_source_offset;
    logic [RAIL_W-1:0]      m_rail_index;
    logic                   m_last;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int fail_count;
    int pending;
    int cycles;
    int produced;

    // Stimulus and receiver coordination.
    bit calm;
    bit no_gap;
    bit hold_req;
    bit hold_served;

    rail_fence_read_address_generator #(
        .OFFSET_BITS(OFFSET_W)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_source_offset(m_source_offset),
        .m_rail_index   (m_rail_index),
        .m_last         (m_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // The checker watches both channels and the register port and keeps its own walk.
    rail_read_checker #(
        .OFFSET_BITS(OFFSET_W)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_source_offset(m_source_offset),
        .m_rail_index   (m_rail_index),
        .m_last         (m_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one item and holds it until it is taken. Afterwards the line either stays
    // busy for the next item or goes quiet for a random burst of idle cycles.
    task automatic send_item(input logic op);
        int gap;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_restart <= op;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (!calm && !no_gap && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Register write; the block takes it on the next rising edge with no handshake.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Stops offering items and waits until every predicted offset has come out. Requests
    // that yield nothing may still be in flight, so a few more cycles are let pass.
    task automatic wait_reads_done();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Result side: random runs of ready and bursts of stall, one long hold-off on request,
    // and a steady ready in the closing stretch.
    initial begin
        int run;
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (calm) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                run = $urandom_range(1, 40);
                @(negedge aclk);
                m_ready <= 1'b1;
                repeat (run - 1) @(negedge aclk);
                if ($urandom_range(0, 1) == 1) begin
                    stall = $urandom_range(1, 17);
                    @(negedge aclk);
                    m_ready <= 1'b0;
                    repeat (stall - 1) @(negedge aclk);
                end
            end
        end
    end

    initial begin
        int seq_no;
        int n;
        int i;
        int extra;
        logic [RAIL_W-1:0] rails;
        logic [LEN_W-1:0]  len;
        logic [15:0]       upper;

        s_valid     = 1'b0;
        s_restart   = WALK_ADVANCE;
        cfg_we      = 1'b0;
        cfg_index   = CFG_RAIL_COUNT;
        cfg_wdata   = '0;
        aresetn     = 1'b0;
        calm        = 1'b0;
        no_gap      = 1'b0;
        hold_req    = 1'b0;
        hold_served = 1'b0;
        produced    = 0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // ---------------- Directed part ----------------

        // Out of reset the walk is idle and the length is zero: an advance while idle
        // gives nothing, and a restart over empty data gives nothing and stays idle.
        send_item(WALK_ADVANCE);
        send_item(WALK_RESTART);
        wait_reads_done();

        // A rail count of zero acts as three; the advance past the end gives nothing.
        write_reg(CFG_RAIL_COUNT, '0);
        write_reg(CFG_DATA_LENGTH, 24'd4);
        send_item(WALK_RESTART);
        repeat (4) send_item(WALK_ADVANCE);
        wait_reads_done();

        // A rail count of one, with junk above the register width, over a single byte.
        write_reg(CFG_RAIL_COUNT, 24'hFFFF01);
        write_reg(CFG_DATA_LENGTH, 24'd1);
        send_item(WALK_RESTART);
        send_item(WALK_ADVANCE);
        wait_reads_done();

        // Widest key over the longest data, with a restart in the middle of a walk.
        write_reg(CFG_RAIL_COUNT, 24'h0000FF);
        write_reg(CFG_DATA_LENGTH, 24'hFFFFFF);
        send_item(WALK_RESTART);
        repeat (2) send_item(WALK_ADVANCE);
        send_item(WALK_RESTART);
        send_item(WALK_ADVANCE);
        wait_reads_done();

        // Shrinking the data under a running walk pushes it on to the next rail, and the
        // smaller key then makes that rail the final one.
        write_reg(CFG_DATA_LENGTH, 24'd3);
        write_reg(CFG_RAIL_COUNT, 24'd2);
        repeat (2) send_item(WALK_ADVANCE);
        wait_reads_done();

        // A key cut below the rail being walked ends the walk with no further offset.
        write_reg(CFG_RAIL_COUNT, 24'h0000FF);
        write_reg(CFG_DATA_LENGTH, 24'd3);
        send_item(WALK_RESTART);
        send_item(WALK_ADVANCE);
        wait_reads_done();
        write_reg(CFG_RAIL_COUNT, 24'd2);
        send_item(WALK_ADVANCE);
        wait_reads_done();

        // ---------------- Random part ----------------
        // Mostly whole walks (a restart and then advances) over short data with assorted
        // keys, now and then long data cut short, stray restarts, register changes in the
        // middle of a walk, and early cut-offs.
        seq_no = 0;
        while (produced < ITEMS_TARGET) begin
            calm = (produced >= CALM_FROM);
            case ($urandom_range(0, 9))
                0:       rails = RAIL_W'($urandom_range(0, 1));
                1:       rails = 8'd2;
                2:       rails = 8'd255;
                3:       rails = RAIL_W'($urandom_range(0, 255));
                default: rails = RAIL_W'($urandom_range(3, 9));
            endcase
            if ($urandom_range(0, 11) == 0)
                len = LEN_W'($urandom_range(0, 24'hFFFFFF));
            else
                len = LEN_W'($urandom_range(0, 48));
            upper = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;

            // One walk runs against a long receiver hold-off with the sender never idle,
            // so the skid stage fills and requests back up.
            if (seq_no == 3) begin
                rails  = 8'd3;
                len    = 24'd48;
                no_gap = 1'b1;
            end

            wait_reads_done();
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_RAIL_COUNT, {upper, rails});
                write_reg(CFG_DATA_LENGTH, len);
            end else begin
                write_reg(CFG_DATA_LENGTH, len);
                write_reg(CFG_RAIL_COUNT, {upper, rails});
            end

            if (seq_no == 3) begin
                hold_req = 1'b1;
                wait (hold_served);
            end

            n = (len > SEQ_CAP) ? SEQ_CAP : int'(len);
            if (!calm && $urandom_range(0, 5) == 0)
                n = $urandom_range(0, n);
            extra = $urandom_range(0, 2);

            send_item(WALK_RESTART);
            for (i = 1; i < n + extra; i++) begin
                if (seq_no == 5 && i == n / 2) begin
                    // The sender pauses mid-walk until every offset so far has come out.
                    wait_reads_done();
                end else if (!calm && seq_no != 3 && $urandom_range(0, 39) == 0) begin
                    wait_reads_done();
                    write_reg(CFG_DATA_LENGTH, CFG_DATA_W'($urandom_range(0, 48)));
                    if ($urandom_range(0, 1) == 1)
                        write_reg(CFG_RAIL_COUNT, CFG_DATA_W'($urandom_range(0, 12)));
                end
                if (!calm && seq_no != 3 && $urandom_range(0, 24) == 0)
                    send_item(WALK_RESTART);
                else
                    send_item(WALK_ADVANCE);
            end
            produced = produced + n;
            no_gap   = 1'b0;
            seq_no++;
        end

        // Let every predicted offset come out, then watch a little longer for strays.
        wait_reads_done();
        repeat (8) @(negedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
